@@ design/sil_pkg.sv @@
// shared types, codes and constants for the sector index lookup and chunker
`default_nettype none
package sil_pkg;

	localparam int DEF_INDEX_BYTES  = 512;
	localparam int DEF_RECORD_BYTES = 7;
	localparam int DEF_MAX_CHUNK    = 64;

	localparam int OFFSET_W  = 9;
	localparam int ADDR_IN_W = 9;
	localparam int BYTE_W    = 8;
	localparam int WORD_W    = 16;
	localparam int CHUNK_W   = 7;
	localparam int REC_FIELD_BYTES = 6;

	localparam logic [BYTE_W-1:0] MAGIC_0 = 8'h44;
	localparam logic [BYTE_W-1:0] MAGIC_1 = 8'h4B;

	localparam logic [1:0] ACT_WRITE  = 2'd0;
	localparam logic [1:0] ACT_LOOKUP = 2'd1;
	localparam logic [1:0] ACT_CHUNK  = 2'd2;
	localparam logic [1:0] ACT_NONE   = 2'd3;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_BAD_MAGIC = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [1:0] ST_NO_XFER   = 2'd3;

	typedef struct packed {
		logic [1:0]           action;
		logic [ADDR_IN_W-1:0] byte_addr;
		logic [BYTE_W-1:0]    byte_value;
		logic [BYTE_W-1:0]    blob_id;
	} in_item_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [WORD_W-1:0]  start_sector;
		logic [WORD_W-1:0]  sector_count;
		logic [WORD_W-1:0]  byte_length;
		logic [WORD_W-1:0]  chunk_sector;
		logic [CHUNK_W-1:0] chunk_size;
		logic               last_chunk;
	} out_item_t;

	// address width that holds offsets, record ends and store addresses
	function automatic int sil_ext_w(input int bytes);
		int aw;
		aw = $clog2(bytes);
		return ((aw > ADDR_IN_W) ? aw : ADDR_IN_W) + 1;
	endfunction

endpackage
`default_nettype wire

@@ design/sil_ram.sv @@
// index sector store: one write port, one registered read port, zero beyond the store
`default_nettype none
module sil_ram
	import sil_pkg::*;
#(
	parameter int INDEX_BYTES = DEF_INDEX_BYTES
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                we,
	input  wire logic [sil_ext_w(INDEX_BYTES)-1:0]   waddr,
	input  wire logic [BYTE_W-1:0]                   wdata,
	input  wire logic                                re,
	input  wire logic [sil_ext_w(INDEX_BYTES)-1:0]   raddr,
	output logic      [BYTE_W-1:0]                   rdata
);

	localparam int AW = $clog2(INDEX_BYTES);
	localparam int EW = sil_ext_w(INDEX_BYTES);

	logic [BYTE_W-1:0] mem [INDEX_BYTES];
	logic [BYTE_W-1:0] rdata_q;
	logic              in_range_q;

	always_ff @(posedge clk) begin
		if (we && (waddr < EW'(INDEX_BYTES))) begin
			mem[waddr[AW-1:0]] <= wdata;
		end
		if (re && (raddr < EW'(INDEX_BYTES))) begin
			rdata_q <= mem[raddr[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_range_q <= 1'b0;
		end else if (re) begin
			in_range_q <= (raddr < EW'(INDEX_BYTES));
		end
	end

	assign rdata = in_range_q ? rdata_q : '0;

endmodule
`default_nettype wire

@@ design/sil_core.sv @@
// request sequencer: store clearing, lookup scan, chunk state and result register
`default_nettype none
module sil_core
	import sil_pkg::*;
#(
	parameter int INDEX_BYTES  = DEF_INDEX_BYTES,
	parameter int RECORD_BYTES = DEF_RECORD_BYTES,
	parameter int MAX_CHUNK    = DEF_MAX_CHUNK
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_wr_en,
	input  wire logic [OFFSET_W-1:0]                 cfg_wr_data,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire in_item_t                            in_data,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output out_item_t                                out_data,
	output logic                                     ram_we,
	output logic      [sil_ext_w(INDEX_BYTES)-1:0]   ram_waddr,
	output logic      [BYTE_W-1:0]                   ram_wdata,
	output logic                                     ram_re,
	output logic      [sil_ext_w(INDEX_BYTES)-1:0]   ram_raddr,
	input  wire logic [BYTE_W-1:0]                   ram_rdata
);

	localparam int AW = $clog2(INDEX_BYTES);
	localparam int EW = sil_ext_w(INDEX_BYTES);
	localparam int FW = REC_FIELD_BYTES * BYTE_W;
	localparam logic [EW-1:0] IB_E = EW'(INDEX_BYTES);
	localparam logic [EW-1:0] RB_E = EW'(RECORD_BYTES);
	localparam logic [WORD_W-1:0] MAXC = WORD_W'(MAX_CHUNK);

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_M0    = 3'd2;
	localparam logic [2:0] S_M1    = 3'd3;
	localparam logic [2:0] S_CNT   = 3'd4;
	localparam logic [2:0] S_SCAN  = 3'd5;
	localparam logic [2:0] S_REC   = 3'd6;
	localparam logic [2:0] S_FIN   = 3'd7;

	logic [2:0]          state_q;
	logic [AW-1:0]       clr_q;
	logic [OFFSET_W-1:0] offset_q;
	logic [WORD_W-1:0]   next_sector_q;
	logic [WORD_W-1:0]   rem_q;
	logic [BYTE_W-1:0]   id_q;
	logic                m0_ok_q;
	logic [BYTE_W-1:0]   cnt_q;
	logic [BYTE_W-1:0]   iss_i_q;
	logic [EW-1:0]       iss_p_q;
	logic [EW-1:0]       cmp_p_q;
	logic [EW-1:0]       ptr_q;
	logic [2:0]          k_q;
	logic [FW-1:0]       fld_q;
	out_item_t           res_q;
	out_item_t           out_q;
	logic                out_valid_q;

	logic [EW-1:0]       off_e;
	logic [EW-1:0]       first_e;
	logic                hit;
	logic                scan_more;
	logic [FW-1:0]       fld_next;
	logic [WORD_W-1:0]   chunk;
	logic                res_take;
	out_item_t           res_fail;
	out_item_t           res_hit;
	out_item_t           res_chunk;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign off_e     = EW'(offset_q);
	assign first_e   = off_e + EW'(3);
	assign hit       = (ram_rdata == id_q);
	assign scan_more = (iss_i_q < cnt_q) && ((iss_p_q + RB_E) <= IB_E);
	assign fld_next  = {ram_rdata, fld_q[FW-1:BYTE_W]};
	assign chunk     = (rem_q > MAXC) ? MAXC : rem_q;
	assign res_take  = (state_q == S_FIN) && (!out_valid_q || out_ready);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = EW'(clr_q);
		ram_wdata = '0;
		ram_re    = 1'b0;
		ram_raddr = off_e;
		res_fail  = '0;
		res_fail.status = (state_q == S_M1) ? ST_BAD_MAGIC : ST_NOT_FOUND;
		res_hit   = '0;
		res_hit.status       = ST_OK;
		res_hit.start_sector = fld_next[WORD_W-1:0];
		res_hit.sector_count = fld_next[2*WORD_W-1:WORD_W];
		res_hit.byte_length  = fld_next[3*WORD_W-1:2*WORD_W];
		res_chunk = '0;
		if (rem_q == '0) begin
			res_chunk.status = ST_NO_XFER;
		end else begin
			res_chunk.chunk_sector = next_sector_q;
			res_chunk.chunk_size   = chunk[CHUNK_W-1:0];
			res_chunk.last_chunk   = (chunk == rem_q);
		end
		case (state_q)
			S_CLEAR: begin
				ram_we = 1'b1;
			end
			S_IDLE: begin
				if (in_valid && (in_data.action == ACT_WRITE)) begin
					ram_we    = 1'b1;
					ram_waddr = EW'(in_data.byte_addr);
					ram_wdata = in_data.byte_value;
				end
				ram_re = in_valid && (in_data.action == ACT_LOOKUP);
			end
			S_M0: begin
				ram_re    = 1'b1;
				ram_raddr = off_e + EW'(1);
			end
			S_M1: begin
				ram_re    = 1'b1;
				ram_raddr = off_e + EW'(2);
			end
			S_CNT: begin
				ram_re    = 1'b1;
				ram_raddr = first_e;
			end
			S_SCAN: begin
				ram_re    = 1'b1;
				ram_raddr = hit ? (cmp_p_q + EW'(1)) : iss_p_q;
			end
			S_REC: begin
				ram_re    = 1'b1;
				ram_raddr = ptr_q;
			end
			default: begin
				ram_re = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_CLEAR;
			clr_q         <= '0;
			offset_q      <= '0;
			next_sector_q <= '0;
			rem_q         <= '0;
			id_q          <= '0;
			m0_ok_q       <= 1'b0;
			cnt_q         <= '0;
			iss_i_q       <= '0;
			iss_p_q       <= '0;
			cmp_p_q       <= '0;
			ptr_q         <= '0;
			k_q           <= '0;
			fld_q         <= '0;
			res_q         <= '0;
			out_q         <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				offset_q <= cfg_wr_data;
			end
			if (res_take) begin
				out_q       <= res_q;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(INDEX_BYTES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						id_q <= in_data.blob_id;
						case (in_data.action)
							ACT_LOOKUP: begin
								res_q   <= '0;
								rem_q   <= '0;
								state_q <= S_M0;
							end
							ACT_CHUNK: begin
								res_q <= res_chunk;
								if (rem_q != '0) begin
									next_sector_q <= next_sector_q + chunk;
									rem_q         <= rem_q - chunk;
								end
								state_q <= S_FIN;
							end
							default: begin
								res_q   <= '0;
								state_q <= S_FIN;
							end
						endcase
					end
				end
				S_M0: begin
					m0_ok_q <= (ram_rdata == MAGIC_0);
					state_q <= S_M1;
				end
				S_M1: begin
					if (!m0_ok_q || (ram_rdata != MAGIC_1)) begin
						res_q   <= res_fail;
						state_q <= S_FIN;
					end else begin
						state_q <= S_CNT;
					end
				end
				S_CNT: begin
					cnt_q <= ram_rdata;
					if ((ram_rdata != '0) && ((first_e + RB_E) <= IB_E)) begin
						cmp_p_q <= first_e;
						iss_p_q <= first_e + RB_E;
						iss_i_q <= BYTE_W'(1);
						state_q <= S_SCAN;
					end else begin
						res_q   <= res_fail;
						state_q <= S_FIN;
					end
				end
				S_SCAN: begin
					if (hit) begin
						ptr_q   <= cmp_p_q + EW'(2);
						k_q     <= '0;
						state_q <= S_REC;
					end else if (scan_more) begin
						cmp_p_q <= iss_p_q;
						iss_p_q <= iss_p_q + RB_E;
						iss_i_q <= iss_i_q + BYTE_W'(1);
					end else begin
						res_q   <= res_fail;
						state_q <= S_FIN;
					end
				end
				S_REC: begin
					fld_q <= fld_next;
					ptr_q <= ptr_q + EW'(1);
					k_q   <= k_q + 3'd1;
					if (k_q == 3'(REC_FIELD_BYTES - 1)) begin
						res_q         <= res_hit;
						next_sector_q <= fld_next[WORD_W-1:0];
						rem_q         <= fld_next[2*WORD_W-1:WORD_W];
						state_q       <= S_FIN;
					end
				end
				S_FIN: begin
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// a failed request carries no lookup answer
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_q.status != ST_OK)) |->
		((out_q.start_sector == '0) && (out_q.sector_count == '0) &&
		(out_q.byte_length == '0) && (out_q.chunk_size == '0)))
		else $error("failed request with nonzero payload");

	// store writes never overlap a lookup
	assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> ((state_q == S_CLEAR) || (state_q == S_IDLE)))
		else $error("store write during lookup");

	// scan stays inside the count and the store
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> ((iss_i_q <= cnt_q) && (iss_p_q <= IB_E)))
		else $error("scan past clamp");

	// a finished result waits while the output register is full
	assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_FIN) && out_valid_q && !out_ready) |=> (state_q == S_FIN))
		else $error("result overwrote pending output");

	// chunk commands never carry a lookup answer
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_q.chunk_size != '0)) |->
		((out_q.status == ST_OK) && (out_q.start_sector == '0)))
		else $error("chunk result mixed with lookup fields");

endmodule
`default_nettype wire

@@ design/sector_index_lookup_and_chunker.sv @@
// Sector index lookup and read chunker, top level.
// Requests arrive on in_valid/in_ready with in_data; each request gives one
// result on out_valid/out_ready with out_data. cfg_wr_en/cfg_wr_data set the
// byte offset of the index header; the user writes it only while no request
// is in flight; the block itself does not enforce this. A byte write, a
// chunk request or an unused action passes from acceptance into the result
// register and then into the output register. A lookup reads the two magic
// bytes and the record count of the header, then scans the records; the
// index store has one read port and the scan reads one record id per cycle,
// then six bytes of the matching record.
// A new request is taken once the previous result sits in the output
// register, even if the receiver has not yet taken it; a stalled receiver
// holds the next finished result in the sequencer and blocks input after it.
// After reset the store is swept to zero with in_ready low; configuration
// writes are taken during the sweep. Reset also drops any armed transfer and
// any pending result.
`default_nettype none
module sector_index_lookup_and_chunker
	import sil_pkg::*;
#(
	parameter int INDEX_BYTES  = DEF_INDEX_BYTES,
	parameter int RECORD_BYTES = DEF_RECORD_BYTES,
	parameter int MAX_CHUNK    = DEF_MAX_CHUNK
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_wr_en,
	input  wire logic [OFFSET_W-1:0] cfg_wr_data,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire in_item_t            in_data,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output out_item_t                out_data
);

	localparam int EW = sil_ext_w(INDEX_BYTES);

	logic              ram_we;
	logic [EW-1:0]     ram_waddr;
	logic [BYTE_W-1:0] ram_wdata;
	logic              ram_re;
	logic [EW-1:0]     ram_raddr;
	logic [BYTE_W-1:0] ram_rdata;

	sil_ram #(
		.INDEX_BYTES (INDEX_BYTES)
	) u_ram (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (ram_we),
		.waddr  (ram_waddr),
		.wdata  (ram_wdata),
		.re     (ram_re),
		.raddr  (ram_raddr),
		.rdata  (ram_rdata)
	);

	sil_core #(
		.INDEX_BYTES  (INDEX_BYTES),
		.RECORD_BYTES (RECORD_BYTES),
		.MAX_CHUNK    (MAX_CHUNK)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_data    (out_data),
		.ram_we      (ram_we),
		.ram_waddr   (ram_waddr),
		.ram_wdata   (ram_wdata),
		.ram_re      (ram_re),
		.ram_raddr   (ram_raddr),
		.ram_rdata   (ram_rdata)
	);

endmodule
`default_nettype wire

@@ test/sector_lookup_checker.sv @@
// checker that predicts and compares every answer of the sector index lookup and chunker
`timescale 1ns / 100ps
module sector_lookup_checker
	import sil_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [OFFSET_W-1:0] cfg_wr_data,
	input  logic                in_valid,
	input  logic                in_ready,
	input  in_item_t            in_data,
	input  logic                out_valid,
	input  logic                out_ready,
	input  out_item_t           out_data,
	output int                  fail_count,
	output int                  pending,
	output int                  found_count,
	output int                  last_count
);

	localparam int INDEX_BYTES  = DEF_INDEX_BYTES;
	localparam int RECORD_BYTES = DEF_RECORD_BYTES;
	localparam int MAX_CHUNK    = DEF_MAX_CHUNK;
	localparam int IW           = $clog2(INDEX_BYTES);

	logic [BYTE_W-1:0]   image [INDEX_BYTES];
	logic [OFFSET_W-1:0] hdr_offset;
	logic [WORD_W-1:0]   xfer_sector;
	logic [WORD_W-1:0]   xfer_left;
	out_item_t           awaited_answers[$];
	int                  errors;
	int                  founds;
	int                  lasts;

	function automatic logic [BYTE_W-1:0] image_byte(input int a);
		return (a < INDEX_BYTES) ? image[a[IW-1:0]] : '0;
	endfunction

	function automatic logic [WORD_W-1:0] image_word(input int a);
		return {image_byte(a + 1), image_byte(a)};
	endfunction

	function automatic out_item_t predict_answer(input in_item_t req);
		out_item_t         r;
		int                base;
		int                first;
		int                fit;
		int                n;
		int                p;
		int                i;
		bit                found;
		logic [WORD_W-1:0] chunk;
		r = '0;
		case (req.action)
			ACT_WRITE: begin
				if (req.byte_addr < INDEX_BYTES)
					image[req.byte_addr] = req.byte_value;
			end
			ACT_LOOKUP: begin
				xfer_left = '0;
				base = int'(hdr_offset);
				first = base + 3;
				if (image_byte(base) != MAGIC_0 || image_byte(base + 1) != MAGIC_1) begin
					r.status = ST_BAD_MAGIC;
				end else begin
					fit = (first <= INDEX_BYTES) ? (INDEX_BYTES - first) / RECORD_BYTES : 0;
					n = int'(image_byte(base + 2));
					if (n > fit)
						n = fit;
					found = 1'b0;
					p = first;
					for (i = 0; i < n; i++) begin
						if (image_byte(p) == req.blob_id) begin
							found = 1'b1;
							break;
						end
						p += RECORD_BYTES;
					end
					if (!found) begin
						r.status = ST_NOT_FOUND;
					end else begin
						xfer_sector = image_word(p + 1);
						xfer_left = image_word(p + 3);
						r.status = ST_OK;
						r.start_sector = xfer_sector;
						r.sector_count = xfer_left;
						r.byte_length = image_word(p + 5);
						founds++;
					end
				end
			end
			ACT_CHUNK: begin
				if (xfer_left == 0) begin
					r.status = ST_NO_XFER;
				end else begin
					chunk = (xfer_left > MAX_CHUNK) ? WORD_W'(MAX_CHUNK) : xfer_left;
					r.chunk_sector = xfer_sector;
					r.chunk_size = chunk[CHUNK_W-1:0];
					r.last_chunk = (chunk == xfer_left);
					if (r.last_chunk)
						lasts++;
					xfer_sector = xfer_sector + chunk;
					xfer_left = xfer_left - chunk;
				end
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	function automatic int field_differs(input string name, input logic [WORD_W-1:0] want,
			input logic [WORD_W-1:0] got);
		if (got === want)
			return 0;
		$display("%0t: %s expected %0d got %0d", $time, name, want, got);
		return 1;
	endfunction

	always @(posedge clk or negedge arst_n) begin : track
		out_item_t want;
		if (!arst_n) begin
			for (int a = 0; a < INDEX_BYTES; a++)
				image[a[IW-1:0]] = '0;
			hdr_offset = '0;
			xfer_sector = '0;
			xfer_left = '0;
			awaited_answers.delete();
			errors = 0;
			founds = 0;
			lasts = 0;
		end else begin
			if (cfg_wr_en)
				hdr_offset = cfg_wr_data;
			if (out_valid && out_ready) begin
				if (awaited_answers.size() == 0) begin
					errors++;
					$display("%0t: answer with no request waiting, got %h", $time, out_data);
				end else begin
					want = awaited_answers.pop_front();
					errors += field_differs("status", WORD_W'(want.status),
							WORD_W'(out_data.status))
						+ field_differs("start_sector", want.start_sector, out_data.start_sector)
						+ field_differs("sector_count", want.sector_count, out_data.sector_count)
						+ field_differs("byte_length", want.byte_length, out_data.byte_length)
						+ field_differs("chunk_sector", want.chunk_sector, out_data.chunk_sector)
						+ field_differs("chunk_size", WORD_W'(want.chunk_size),
							WORD_W'(out_data.chunk_size))
						+ field_differs("last_chunk", WORD_W'(want.last_chunk),
							WORD_W'(out_data.last_chunk));
				end
			end
			if (in_valid && in_ready)
				awaited_answers.push_back(predict_answer(in_data));
		end
		fail_count <= errors;
		pending <= awaited_answers.size();
		found_count <= founds;
		last_count <= lasts;
	end

endmodule

@@ test/sector_index_lookup_and_chunker_tb.sv @@
// testbench top for the sector index lookup and chunker: stimulus, idling and verdict
`timescale 1ns / 100ps
module sector_index_lookup_and_chunker_tb;
	import sil_pkg::*;

	localparam int RANDOM_ITEMS = 1950;
	localparam int HOLD_CYCLES  = 250;
	localparam int QUIET_LIMIT  = 5000;
	localparam int SETTLE       = 120;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_wr_en = 1'b0;
	logic [OFFSET_W-1:0] cfg_wr_data = '0;
	logic                in_valid = 1'b0;
	in_item_t            in_data = '0;
	logic                out_ready = 1'b0;
	logic                in_ready;
	logic                out_valid;
	out_item_t           out_data;

	int fail_count;
	int pending;
	int found_count;
	int last_count;

	int   send_idle_pct = 17;
	int   recv_idle_pct = 76;
	logic hold_token = 1'b0;
	logic hold_seen = 1'b0;
	int   hold_left = 0;
	int   quiet_cycles = 0;
	int   req_count = 0;
	int   offsets_used = 0;
	int   act_count[4] = '{0, 0, 0, 0};

	sector_index_lookup_and_chunker DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	sector_lookup_checker answer_check (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.fail_count(fail_count),
		.pending(pending),
		.found_count(found_count),
		.last_count(last_count)
	);

	always #10 clk = ~clk;

	// receiver side, with a long hold-off started by a toggle of hold_token
	always @(posedge clk) begin
		if (hold_token != hold_seen) begin
			hold_seen <= hold_token;
			hold_left <= HOLD_CYCLES;
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == QUIET_LIMIT) begin
			$display("%0t: no request or answer moved for %0d cycles", $time, QUIET_LIMIT);
			$display("end of test: mismatches");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic in_item_t random_request(input logic [1:0] act);
		in_item_t r;
		r.action = act;
		r.byte_addr = ADDR_IN_W'($urandom_range(511));
		r.byte_value = BYTE_W'($urandom_range(255));
		r.blob_id = BYTE_W'($urandom_range(255));
		return r;
	endfunction

	task automatic send_request(input in_item_t r);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= r;
		req_count++;
		act_count[r.action]++;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic write_byte(input int addr, input logic [7:0] value);
		in_item_t r;
		r = random_request(ACT_WRITE);
		r.byte_addr = ADDR_IN_W'(addr);
		r.byte_value = value;
		send_request(r);
	endtask

	task automatic write_word(input int addr, input logic [15:0] value);
		write_byte(addr, value[7:0]);
		write_byte(addr + 1, value[15:8]);
	endtask

	task automatic lookup_blob(input logic [7:0] id);
		in_item_t r;
		r = random_request(ACT_LOOKUP);
		r.blob_id = id;
		send_request(r);
	endtask

	task automatic next_chunk();
		send_request(random_request(ACT_CHUNK));
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	task automatic set_offset(input int value);
		wait_drained();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= OFFSET_W'(value);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		offsets_used++;
	endtask

	initial begin : stimulus
		int               off;
		int               fit;
		int               nrec;
		int               ops;
		int               sel;
		int               seg;
		int               phase;
		int               base;
		int               random_start;
		bit               held;
		logic [7:0]       ids[72];
		logic [15:0]      sectors;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		set_offset(0);

		// empty store, nothing armed, unused action
		lookup_blob(8'h00);
		next_chunk();
		send_request(random_request(ACT_NONE));
		write_byte(0, MAGIC_0);
		write_byte(1, MAGIC_1);
		lookup_blob(8'h00);
		// count clamped to the records that fit; zeroed record gives a zero-sector blob
		write_byte(2, 8'hFF);
		lookup_blob(8'h00);
		next_chunk();
		write_byte(3, 8'h5A);
		write_word(4, 16'hFFF0);
		write_word(6, 16'h0081);
		write_word(8, 16'hFFFF);
		lookup_blob(8'h5A);
		repeat (4) next_chunk();
		write_byte(500, 8'hA5);
		lookup_blob(8'hA5);
		write_byte(507, 8'hC3);
		lookup_blob(8'hC3);
		// failed lookup disarms
		lookup_blob(8'h5A);
		lookup_blob(8'h77);
		next_chunk();
		// header near the end of the store
		set_offset(509);
		write_byte(509, MAGIC_0);
		write_byte(510, MAGIC_1);
		write_byte(511, 8'h05);
		lookup_blob(8'h00);
		set_offset(511);
		lookup_blob(8'h00);

		random_start = req_count;
		held = 1'b0;
		phase = 0;
		while (req_count < random_start + RANDOM_ITEMS) begin
			seg = (req_count - random_start) * 3 / RANDOM_ITEMS;
			case (phase % 8)
				0: off = 0;
				1: off = 509;
				2: off = 511;
				3: off = 510;
				4: off = $urandom_range(509, 440);
				default: off = $urandom_range(509);
			endcase
			set_offset(off);
			send_idle_pct = (seg == 0) ? 17 : (seg == 1) ? 76 : 0;
			recv_idle_pct <= (seg == 0) ? 76 : (seg == 1) ? 17 : 0;

			nrec = 0;
			if (off <= 509) begin
				write_byte(off, ($urandom_range(99) < 8) ? 8'($urandom) : MAGIC_0);
				write_byte(off + 1, ($urandom_range(99) < 8) ? 8'($urandom) : MAGIC_1);
				fit = (509 - off) / 7;
				nrec = (phase % 10 == 9) ? fit : $urandom_range(12, 1);
				if (nrec > fit)
					nrec = fit;
				write_byte(off + 2,
					8'(($urandom_range(99) < 15) ? $urandom_range(255, nrec) : nrec));
				for (int i = 0; i < nrec; i++) begin
					base = off + 3 + i * 7;
					ids[i[6:0]] = 8'(($urandom_range(1)) ? $urandom_range(15) :
						$urandom_range(255));
					sel = $urandom_range(99);
					sectors = (sel < 15) ? 16'd0 : (sel < 55) ? 16'($urandom_range(64, 1)) :
						(sel < 90) ? 16'($urandom_range(400, 65)) : 16'($urandom);
					write_byte(base, ids[i[6:0]]);
					write_word(base + 1, 16'($urandom));
					write_word(base + 3, sectors);
					write_word(base + 5, 16'($urandom));
				end
			end else begin
				write_byte(off, MAGIC_0);
				if (off == 510)
					write_byte(511, MAGIC_1);
			end

			if (seg == 2 && !held) begin
				hold_token <= ~hold_token;
				held = 1'b1;
			end

			ops = $urandom_range(50, 20);
			for (int k = 0; k < ops && req_count < random_start + RANDOM_ITEMS; k++) begin
				sel = $urandom_range(99);
				if (sel < 55) begin
					lookup_blob((nrec > 0) ? ids[7'($urandom_range(nrec - 1))] : 8'($urandom));
					repeat ($urandom_range(6, 1)) next_chunk();
				end else if (sel < 70) begin
					lookup_blob(8'($urandom));
				end else if (sel < 80) begin
					next_chunk();
				end else if (sel < 92) begin
					write_byte($urandom_range(511), 8'($urandom));
				end else begin
					send_request(random_request(ACT_NONE));
				end
			end
			phase++;
		end

		wait_drained();
		repeat (SETTLE) @(posedge clk);
		$display("%0d requests: %0d writes, %0d lookups, %0d chunk, %0d unused; %0d offsets",
			req_count, act_count[ACT_WRITE], act_count[ACT_LOOKUP], act_count[ACT_CHUNK],
			act_count[ACT_NONE], offsets_used);
		$display("%0d lookups found a blob, %0d transfers ran to their last chunk",
			found_count, last_count);
		if (fail_count == 0 && pending == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
